[hw/rtl/cwla_pkg.sv]
// Shared constants, types and helper functions of the credit-weighted list arbiter.
package cwla_pkg;

  localparam int MAX_QUEUES  = 8;
  localparam int MAX_LAYERS  = 16;
  localparam int BUDGET_BITS = 16;

  localparam int ENTRIES = MAX_LAYERS * MAX_QUEUES;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QIDX_W  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int SLOT_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int QCNT_W  = $clog2(MAX_QUEUES + 1);
  localparam int SUM_W   = ((BUDGET_BITS > 10) ? BUDGET_BITS : 10) + 1;

  localparam int CMD_W   = 2;
  localparam int LSLOT_W = 4;
  localparam int MASK_W  = 8;
  localparam int RR_W    = 3;
  localparam int QI_W    = 3;
  localparam int COST_W  = 16;
  localparam int BOOST_W = 8;
  localparam int QC_W    = 4;
  localparam int OUT_W   = 16;
  localparam int CFGD_W  = 8;
  localparam int RAM_W   = BUDGET_BITS + COST_W;

  localparam logic [0:0] REG_BOOST  = 1'b0;
  localparam logic [0:0] REG_QCOUNT = 1'b1;

  typedef logic signed [BUDGET_BITS-1:0] budget_t;
  typedef logic signed [SUM_W-1:0]       wide_t;

  localparam budget_t BUDGET_MAX = {1'b0, {(BUDGET_BITS-1){1'b1}}};
  localparam budget_t BUDGET_MIN = {1'b1, {(BUDGET_BITS-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_SELECT = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic {
    ALU_ADD,
    ALU_CMP
  } alu_op_t;

  typedef struct packed {
    budget_t sum;
    logic    gt;
    logic    eq;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RR_WALK,
    ST_RD,
    ST_RD_WAIT,
    ST_SCAN,
    ST_SEL_FIN,
    ST_REC_RD,
    ST_REC_BOOST,
    ST_REC_DEC,
    ST_CLEAR,
    ST_DONE
  } state_t;

  function automatic budget_t sat_budget(wide_t v);
    budget_t r;
    if (v > wide_t'(BUDGET_MAX)) r = BUDGET_MAX;
    else if (v < wide_t'(BUDGET_MIN)) r = BUDGET_MIN;
    else r = budget_t'(v);
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] budget_out16(budget_t b);
    logic signed [31:0] w;
    w = 32'(b);
    return w[OUT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(logic [LSLOT_W-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << LSLOT_W); i++) begin
      if (v == LSLOT_W'(i)) r = SLOT_W'(i % MAX_LAYERS);
    end
    return r;
  endfunction

  // v mod n for a small v, by repeated subtraction
  function automatic logic [QIDX_W-1:0] mod_small(logic [RR_W-1:0] v, logic [QCNT_W-1:0] n);
    logic [7:0] r;
    r = 8'(v);
    for (int i = 0; i < (1 << RR_W) - 1; i++) begin
      if (r >= 8'(n)) r = r - 8'(n);
    end
    return QIDX_W'(r);
  endfunction

  function automatic logic [QCNT_W-1:0] active_n(logic [QC_W-1:0] qc);
    logic [QCNT_W-1:0] n;
    if (qc == '0) n = QCNT_W'(1);
    else if (32'(qc) > MAX_QUEUES) n = QCNT_W'(MAX_QUEUES);
    else n = QCNT_W'(qc);
    return n;
  endfunction

  function automatic logic mask_bit(logic [MASK_W-1:0] m, int unsigned k);
    return (k < MASK_W) && m[k[2:0]];
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(logic [SLOT_W-1:0] s,
                                                   logic [QIDX_W-1:0] q);
    return ADDR_W'(32'(s) * MAX_QUEUES + 32'(q));
  endfunction

endpackage

[hw/rtl/cwla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cwla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[hw/rtl/cwla_alu.sv]
// Shared adder of the arbiter: saturating budget add and signed budget compare.
module cwla_alu import cwla_pkg::*; (
  input  alu_op_t  op,
  input  wide_t    a,
  input  wide_t    b,
  output alu_res_t res
);

  wide_t bx;
  wide_t s;

  // compare runs as a - b through the same adder
  assign bx = (op == ALU_CMP) ? ~b : b;
  assign s  = a + bx + wide_t'(op == ALU_CMP);

  always_comb begin
    res.sum = sat_budget(s);
    res.gt  = !s[SUM_W-1] && (s != '0);
    res.eq  = (s == '0);
  end

endmodule

[hw/rtl/credit_weighted_list_arbiter.sv]
// Top level of the credit-weighted list arbiter: sequencer, state memory and result register.
//
// One transaction at a time: in_ready is high only while the sequencer is idle, and a finished
// result waits in the output register while the next transaction is taken. Budgets and last
// costs live in one memory with a single read port and registered read data; every stored
// value passes through that port and one shared adder, one entry per cycle. Credit-mode select
// reads all MAX_QUEUES budgets of the slot in ST_SCAN, then prefers rr_index on a tie in ST_SEL_FIN
// before ST_DONE. Round-robin select walks 1 to queue_count queues, then reads the granted budget
// in ST_RD and ST_RD_WAIT; record steps through read, boost add, decrement and write-back; clear
// passes through ST_CLEAR and unknown commands go to ST_DONE. Per-entry valid bits stand for the
// zero reset value, so no clearing pass runs after reset and a clear drops the slot's valid bits.
module credit_weighted_list_arbiter import cwla_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [LSLOT_W-1:0]       in_layer_slot,
  input  logic [MASK_W-1:0]        in_nonempty_mask,
  input  logic [RR_W-1:0]          in_rr_index,
  input  logic [QI_W-1:0]          in_queue_index,
  input  logic [COST_W-1:0]        in_cost_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [QI_W-1:0]          out_granted_queue,
  output logic                     out_any_nonempty,
  output logic signed [OUT_W-1:0]  out_budget_now,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFGD_W-1:0]        cfg_wdata
);

  state_t state_r, state_nxt;

  logic [BOOST_W-1:0] boost_r;
  logic [QC_W-1:0]    qcount_r;

  logic [SLOT_W-1:0]  slot_r;
  logic [MASK_W-1:0]  mask_r;
  logic [RR_W-1:0]    rr_r;
  logic [QI_W-1:0]    qi_r;
  logic [COST_W-1:0]  cost_r;

  logic [QIDX_W-1:0]  q_r;
  logic [QCNT_W-1:0]  off_r;
  logic [QCNT_W-1:0]  k_r;
  logic               pv_r;
  logic [QIDX_W-1:0]  ck_r;
  budget_t            best_r;
  logic [QIDX_W-1:0]  bestk_r;
  logic               found_r;
  budget_t            rrb_r;
  budget_t            bud_r;

  logic [QI_W-1:0]    res_grant_r;
  logic               res_any_r;
  logic [OUT_W-1:0]   res_bud_r;

  logic               out_valid_r;
  logic [QI_W-1:0]    out_grant_r;
  logic               out_any_r;
  logic [OUT_W-1:0]   out_bud_r;

  logic [ENTRIES-1:0] valid_r;
  logic               rd_vld_r;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;

  alu_op_t            alu_op;
  wide_t              alu_a, alu_b;
  alu_res_t           alu_res;

  logic [QCNT_W-1:0]  n_act;
  logic               walk_hit, walk_last;
  logic               scan_issue, scan_cand, scan_last;
  logic               grant_store, rr_ok, out_free;
  budget_t            rd_budget;
  logic [COST_W-1:0]  rd_cost;

  cwla_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cwla_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // an entry never written since reset or clear reads as zero
  assign rd_budget = rd_vld_r ? budget_t'(ram_rdata[RAM_W-1 -: BUDGET_BITS]) : '0;
  assign rd_cost   = rd_vld_r ? ram_rdata[COST_W-1:0] : '0;

  assign n_act       = active_n(qcount_r);
  assign walk_hit    = mask_bit(mask_r, 32'(q_r));
  assign walk_last   = (off_r + QCNT_W'(1)) == n_act;
  assign scan_issue  = 32'(k_r) < MAX_QUEUES;
  assign scan_cand   = pv_r && mask_bit(mask_r, 32'(ck_r)) && (32'(ck_r) < 32'(n_act));
  assign scan_last   = pv_r && (32'(ck_r) == MAX_QUEUES - 1);
  assign grant_store = 32'(res_grant_r) < MAX_QUEUES;
  assign rr_ok       = (32'(rr_r) < 32'(n_act)) && mask_bit(mask_r, 32'(rr_r));
  assign out_free    = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_SELECT: state_nxt = (boost_r == '0) ? ST_RR_WALK : ST_SCAN;
            CMD_RECORD: state_nxt = (32'(in_queue_index) < MAX_QUEUES) ? ST_REC_RD : ST_DONE;
            CMD_CLEAR:  state_nxt = ST_CLEAR;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RR_WALK:   if (walk_hit || walk_last) state_nxt = ST_RD;
      ST_RD:        state_nxt = ST_RD_WAIT;
      ST_RD_WAIT:   state_nxt = ST_DONE;
      ST_SCAN:      if (scan_last) state_nxt = ST_SEL_FIN;
      ST_SEL_FIN:   state_nxt = ST_DONE;
      ST_REC_RD:    state_nxt = ST_REC_BOOST;
      ST_REC_BOOST: state_nxt = ST_REC_DEC;
      ST_REC_DEC:   state_nxt = ST_DONE;
      ST_CLEAR:     state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // memory port and shared adder control
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = entry_addr(slot_r, QIDX_W'(qi_r));
    ram_wdata = {alu_res.sum, cost_r};
    alu_op    = ALU_CMP;
    alu_a     = '0;
    alu_b     = '0;
    unique case (state_r)
      ST_RD: begin
        ram_re    = grant_store;
        ram_raddr = entry_addr(slot_r, QIDX_W'(res_grant_r));
      end
      ST_SCAN: begin
        ram_re    = scan_issue;
        ram_raddr = entry_addr(slot_r, QIDX_W'(k_r));
        alu_a     = wide_t'(rd_budget);
        alu_b     = wide_t'(best_r);
      end
      ST_SEL_FIN: begin
        alu_a = wide_t'(rrb_r);
        alu_b = wide_t'(best_r);
      end
      ST_REC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = entry_addr(slot_r, QIDX_W'(qi_r));
      end
      ST_REC_BOOST: begin
        alu_op = ALU_ADD;
        alu_a  = wide_t'(rd_budget);
        alu_b  = wide_t'(boost_r);
      end
      ST_REC_DEC: begin
        alu_op = ALU_ADD;
        alu_a  = wide_t'(bud_r);
        alu_b  = '1;
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      boost_r     <= '0;
      qcount_r    <= QC_W'(1);
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == ST_SCAN) && scan_issue;
      if (cfg_we) begin
        if (cfg_index == REG_BOOST) boost_r <= cfg_wdata[BOOST_W-1:0];
        else if (cfg_index == REG_QCOUNT) qcount_r <= cfg_wdata[QC_W-1:0];
      end
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_CLEAR) begin
        for (int k = 0; k < MAX_QUEUES; k++) begin
          valid_r[entry_addr(slot_r, QIDX_W'(k))] <= 1'b0;
        end
      end
      if (ram_we) valid_r[ram_waddr] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ram_re) rd_vld_r <= valid_r[ram_raddr];
    if (in_valid && in_ready) begin
      slot_r      <= slot_of(in_layer_slot);
      mask_r      <= in_nonempty_mask;
      rr_r        <= in_rr_index;
      qi_r        <= in_queue_index;
      cost_r      <= in_cost_value;
      q_r         <= mod_small(in_rr_index, n_act);
      off_r       <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
      best_r      <= '0;
      bestk_r     <= '0;
      rrb_r       <= '0;
      res_grant_r <= '0;
      res_any_r   <= 1'b0;
      res_bud_r   <= '0;
    end
    case (state_r)
      ST_RR_WALK: begin
        if (walk_hit) begin
          res_grant_r <= QI_W'(q_r);
          res_any_r   <= 1'b1;
        end else if (walk_last) begin
          res_grant_r <= rr_r;
        end else begin
          // advance modulo the active queue count
          q_r   <= ((QCNT_W'(q_r) + QCNT_W'(1)) == n_act) ? '0 : q_r + QIDX_W'(1);
          off_r <= off_r + QCNT_W'(1);
        end
      end
      ST_RD_WAIT: begin
        res_bud_r <= grant_store ? budget_out16(rd_budget) : '0;
      end
      ST_SCAN: begin
        if (scan_issue) k_r <= k_r + QCNT_W'(1);
        ck_r <= QIDX_W'(k_r);
        if (pv_r && 32'(ck_r) == 32'(rr_r)) rrb_r <= rd_budget;
        // strict greater keeps the lowest index on a tie
        if (scan_cand && (!found_r || alu_res.gt)) begin
          best_r  <= rd_budget;
          bestk_r <= ck_r;
          found_r <= 1'b1;
        end
      end
      ST_SEL_FIN: begin
        if (found_r) begin
          res_grant_r <= (rr_ok && alu_res.eq) ? rr_r : QI_W'(bestk_r);
          res_any_r   <= 1'b1;
          res_bud_r   <= budget_out16(best_r);
        end else begin
          res_grant_r <= rr_r;
          res_any_r   <= 1'b0;
          res_bud_r   <= budget_out16(rrb_r);
        end
      end
      ST_REC_BOOST: begin
        bud_r <= (rd_vld_r && cost_r < rd_cost) ? alu_res.sum : rd_budget;
      end
      ST_REC_DEC: begin
        res_bud_r <= budget_out16(alu_res.sum);
      end
      ST_DONE: begin
        if (out_free) begin
          out_grant_r <= res_grant_r;
          out_any_r   <= res_any_r;
          out_bud_r   <= res_bud_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_granted_queue = out_grant_r;
  assign out_any_nonempty  = out_any_r;
  assign out_budget_now    = out_bud_r;

endmodule

[hw/rtl/cwla_checker.sv]
// Port-level checker for the credit-weighted list arbiter and its bind.
module cwla_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_granted_queue,
  input logic              out_any_nonempty,
  input logic signed [15:0] out_budget_now
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_queue) &&
      $stable(out_any_nonempty) && $stable(out_budget_now))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_idle_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid)
    else $error("returned to idle without presenting a result");

  a_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while sequencer busy");

endmodule

bind credit_weighted_list_arbiter cwla_checker u_cwla_checker (.*);
